FILE: sv/cfpt_pkg.sv
`default_nettype none

package cfpt_pkg;

   // Result and register widths fixed by the interface.
   localparam int TIP_W = 19;
   localparam int FC_W = 3;
   localparam int OFFSET_W = 8;
   localparam logic [OFFSET_W-1:0] OFFSET_RESET = 8'd58;

   // APB-style register port.
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam logic REG_TOOL_OFFSET = 1'b0;

   localparam int DEF_MAX_DIGITS = 3;
   localparam int DEF_FRAC_BITS = 8;

   // Characters of the frame syntax.
   localparam logic [7:0] CH_OPEN = 8'h5B;
   localparam logic [7:0] CH_CLOSE = 8'h5D;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_ZERO = 8'h30;
   localparam logic [7:0] CH_NINE = 8'h39;

   typedef struct packed {
      logic byte_en;
      logic sq_en;
      logic r2_en;
      logic init_en;
      logic iter_en;
      logic fin_en;
      logic pass;
      logic load_out;
   } cfpt_cmd_type;

   typedef struct packed {
      logic frame_end;
      logic r2_zero;
   } cfpt_stat_type;

   // Bits needed for a decimal number of the given digit count.
   function automatic int acc_width(input int digits);
      int p;
      p = 1;
      for (int i = 0; i < digits; i++) begin
         p = p * 10;
      end
      return $clog2(p);
   endfunction

endpackage

`default_nettype wire

FILE: sv/cfpt_csr.sv
`default_nettype none

module cfpt_csr import cfpt_pkg::*; (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   csr_psel,
   input  wire                   csr_penable,
   input  wire                   csr_pwrite,
   input  wire [CSR_ADDR_W-1:0]  csr_paddr,
   input  wire [CSR_DATA_W-1:0]  csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output logic [OFFSET_W-1:0]   tool_offset
);

   logic [OFFSET_W-1:0] tool_offset_ff, tool_offset_in;
   logic                reg_index;
   logic                write_hit;

   assign reg_index = csr_paddr[CSR_ADDR_W-1];
   assign csr_pready = 1'b1;
   assign write_hit = csr_psel && csr_penable && csr_pwrite && csr_pready
                      && (reg_index == REG_TOOL_OFFSET);

   always_comb begin
      tool_offset_in = tool_offset_ff;
      if (write_hit) begin
         tool_offset_in = csr_pwdata[OFFSET_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tool_offset_ff <= OFFSET_RESET;
      end else begin
         tool_offset_ff <= tool_offset_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (reg_index == REG_TOOL_OFFSET) begin
         csr_prdata = CSR_DATA_W'(tool_offset_ff);
      end
   end

   assign tool_offset = tool_offset_ff;

endmodule

`default_nettype wire

FILE: sv/cfpt_ctrl.sv
`default_nettype none

module cfpt_ctrl import cfpt_pkg::*; #(
   parameter int FRAC_BITS = DEF_FRAC_BITS
) (
   input  wire           clock,
   input  wire           reset,
   input  wire           req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  wire           rsp_ready,
   input  cfpt_stat_type stat,
   output cfpt_cmd_type  cmd
);

   localparam int QW = OFFSET_W + FRAC_BITS;
   localparam int CW = $clog2(QW);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_SQ   = 3'd1;
   localparam logic [2:0] ST_R2   = 3'd2;
   localparam logic [2:0] ST_INIT = 3'd3;
   localparam logic [2:0] ST_ITER = 3'd4;
   localparam logic [2:0] ST_FIN  = 3'd5;
   localparam logic [2:0] ST_LOAD = 3'd6;

   logic [2:0]    state_ff, state_in;
   logic          pass_ff, pass_in;
   logic [CW-1:0] iter_ff, iter_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          accept;

   // A closing bracket is held off while the previous result is still waiting.
   assign req_ready = (state_ff == ST_IDLE) && !(rsp_valid_ff && stat.frame_end);
   assign accept = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      pass_in = pass_ff;
      iter_in = iter_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (accept && stat.frame_end) begin
               state_in = ST_SQ;
               pass_in = 1'b0;
            end
         end
         ST_SQ: begin
            state_in = ST_R2;
         end
         ST_R2: begin
            state_in = ST_INIT;
         end
         ST_INIT: begin
            if (stat.r2_zero) begin
               state_in = ST_LOAD;
            end else begin
               state_in = ST_ITER;
               iter_in = CW'(QW - 1);
            end
         end
         ST_ITER: begin
            if (iter_ff == '0) begin
               state_in = ST_FIN;
            end else begin
               iter_in = iter_ff - CW'(1);
            end
         end
         ST_FIN: begin
            if (!pass_ff) begin
               pass_in = 1'b1;
               state_in = ST_SQ;
            end else begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            rsp_valid_in = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pass_ff <= 1'b0;
         iter_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pass_ff <= pass_in;
         iter_ff <= iter_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      cmd.byte_en = accept;
      cmd.sq_en = (state_ff == ST_SQ);
      cmd.r2_en = (state_ff == ST_R2);
      cmd.init_en = (state_ff == ST_INIT);
      cmd.iter_en = (state_ff == ST_ITER);
      cmd.fin_en = (state_ff == ST_FIN);
      cmd.pass = pass_ff;
      cmd.load_out = (state_ff == ST_LOAD);
   end

   assign rsp_valid = rsp_valid_ff;

   // The output register must be free whenever a frame starts its computation.
   a_frame_needs_free_output: assert property (@(posedge clock) disable iff (reset)
      accept && stat.frame_end |-> !rsp_valid_ff)
      else $error("frame accepted while a result is pending");

   // A nonzero radius always runs the full root search.
   a_search_length: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_INIT && !stat.r2_zero |=> state_ff == ST_ITER
      && iter_ff == CW'(QW - 1))
      else $error("root search started with a wrong bit count");

   a_load_shows_result: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_LOAD |=> rsp_valid_ff && state_ff == ST_IDLE)
      else $error("loaded result not presented");

endmodule

`default_nettype wire

FILE: sv/cfpt_dp.sv
`default_nettype none

module cfpt_dp import cfpt_pkg::*; #(
   parameter int MAX_DIGITS = DEF_MAX_DIGITS,
   parameter int FRAC_BITS = DEF_FRAC_BITS
) (
   input  wire                      clock,
   input  wire                      reset,
   input  cfpt_cmd_type             cmd,
   output cfpt_stat_type            stat,
   input  wire [OFFSET_W-1:0]       tool_offset,
   input  wire [7:0]                req_rx_byte,
   output logic signed [TIP_W-1:0]  rsp_x_tip,
   output logic signed [TIP_W-1:0]  rsp_y_tip,
   output logic [FC_W-1:0]          rsp_frame_count,
   output logic                     rsp_zero_radius
);

   localparam int AW = acc_width(MAX_DIGITS);
   localparam int DCW = $clog2(MAX_DIGITS + 1);
   localparam int QW = OFFSET_W + FRAC_BITS;
   localparam int MW = OFFSET_W + AW;
   localparam int R2W = 2 * AW + 1;
   localparam int SQW = 2 * MW;
   localparam int SHW = 2 * FRAC_BITS + 2;
   localparam int WW = 2 * QW + 2 * AW + 3;
   localparam int VSW = AW + FRAC_BITS;
   localparam int DW = ((VSW > QW + 1) ? VSW : QW + 1) + 1;
   localparam int SW = (DW > TIP_W) ? DW : TIP_W;
   localparam int TIP_MAX_I = 2 ** (TIP_W - 1) - 1;
   localparam int TIP_MIN_I = -(2 ** (TIP_W - 1));

   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_X    = 2'd1;
   localparam logic [1:0] PH_Y    = 2'd2;

   // Frame parser.
   logic [1:0]      phase_ff, phase_in;
   logic [AW-1:0]   x_ff, x_in;
   logic [AW-1:0]   y_ff, y_in;
   logic [DCW-1:0]  dc_ff, dc_in;
   logic [FC_W-1:0] cnt_ff, cnt_in;
   logic            is_digit;
   logic [3:0]      digit;
   logic [AW+3:0]   x_next, y_next;
   logic            in_frame;

   assign is_digit = req_rx_byte inside {[CH_ZERO:CH_NINE]};
   assign digit = req_rx_byte[3:0];
   assign in_frame = (phase_ff == PH_X) || (phase_ff == PH_Y);
   assign x_next = (AW+4)'({x_ff, 3'b000}) + (AW+4)'({x_ff, 1'b0}) + (AW+4)'(digit);
   assign y_next = (AW+4)'({y_ff, 3'b000}) + (AW+4)'({y_ff, 1'b0}) + (AW+4)'(digit);
   assign stat.frame_end = (req_rx_byte == CH_CLOSE) && (phase_ff == PH_Y) && (dc_ff != '0);

   always_comb begin
      phase_in = phase_ff;
      x_in = x_ff;
      y_in = y_ff;
      dc_in = dc_ff;
      cnt_in = cnt_ff;
      if (cmd.byte_en) begin
         if (req_rx_byte == CH_OPEN) begin
            phase_in = PH_X;
            x_in = '0;
            y_in = '0;
            dc_in = '0;
         end else if (!in_frame) begin
            phase_in = PH_IDLE;
         end else if (is_digit) begin
            if (dc_ff >= DCW'(MAX_DIGITS)) begin
               phase_in = PH_IDLE;
               dc_in = '0;
            end else begin
               if (phase_ff == PH_X) begin
                  x_in = x_next[AW-1:0];
               end else begin
                  y_in = y_next[AW-1:0];
               end
               dc_in = dc_ff + DCW'(1);
            end
         end else if (req_rx_byte == CH_COMMA && phase_ff == PH_X && dc_ff != '0) begin
            phase_in = PH_Y;
            dc_in = '0;
         end else begin
            // A good closing bracket counts the frame; anything else drops it.
            if (stat.frame_end) begin
               cnt_in = cnt_ff + FC_W'(1);
            end
            phase_in = PH_IDLE;
            dc_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         x_ff <= '0;
         y_ff <= '0;
         dc_ff <= '0;
         cnt_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         x_ff <= x_in;
         y_ff <= y_in;
         dc_ff <= dc_in;
         cnt_ff <= cnt_in;
      end
   end

   // Radial offset. With amp = offset * 2^FRAC_BITS and S = 4 * amp^2 * v^2,
   // q is the largest value with (2q - 1)^2 * r2 <= S. The search runs over
   // p = q - 1, one bit per cycle from the top, keeping A = (2p + 1)^2 * r2
   // and the shifted cross term so that each step is only adds and shifts.
   logic [2*AW-1:0]       xx_ff, yy_ff;
   logic [MW-1:0]         m_ff;
   logic [R2W-1:0]        r2_ff;
   logic [SQW-1:0]        s_ff;
   logic [WW-1:0]         a_ff, bs_ff, rs_ff;
   logic [QW-1:0]         p_ff;
   logic                  le_ff;
   logic                  zero_ff;
   logic signed [TIP_W-1:0] x_hold_ff, y_hold_ff;
   logic signed [TIP_W-1:0] rsp_x_tip_ff, rsp_y_tip_ff;
   logic [FC_W-1:0]       rsp_frame_count_ff;
   logic                  rsp_zero_radius_ff;

   logic [AW-1:0]         v_sel;
   logic [WW-1:0]         s_full;
   logic [WW-1:0]         r2_ext;
   logic [WW-1:0]         trial;
   logic                  take;
   logic [QW:0]           q;
   logic [VSW-1:0]        vs;
   logic signed [DW-1:0]  diff;
   logic signed [SW-1:0]  dext;
   logic signed [TIP_W-1:0] tip;

   assign v_sel = cmd.pass ? y_ff : x_ff;
   assign s_full = WW'(s_ff) << SHW;
   assign r2_ext = WW'(r2_ff);
   assign trial = a_ff + bs_ff + rs_ff;
   assign take = (trial <= s_full);
   assign stat.r2_zero = (r2_ff == '0);
   assign q = le_ff ? ((QW+1)'(p_ff) + (QW+1)'(1)) : '0;
   assign vs = {v_sel, {FRAC_BITS{1'b0}}};
   assign diff = $signed(DW'(vs)) - $signed(DW'(q));
   assign dext = SW'(diff);

   always_comb begin
      if (dext > SW'(TIP_MAX_I)) begin
         tip = {1'b0, {(TIP_W-1){1'b1}}};
      end else if (dext < SW'(TIP_MIN_I)) begin
         tip = {1'b1, {(TIP_W-1){1'b0}}};
      end else begin
         tip = dext[TIP_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.sq_en) begin
         xx_ff <= (2*AW)'(x_ff) * (2*AW)'(x_ff);
         yy_ff <= (2*AW)'(y_ff) * (2*AW)'(y_ff);
         m_ff <= MW'(tool_offset) * MW'(v_sel);
      end
      if (cmd.r2_en) begin
         r2_ff <= R2W'(xx_ff) + R2W'(yy_ff);
         s_ff <= SQW'(m_ff) * SQW'(m_ff);
      end
      if (cmd.init_en) begin
         a_ff <= r2_ext;
         bs_ff <= r2_ext << (QW + 1);
         rs_ff <= r2_ext << (2 * QW);
         p_ff <= '0;
         le_ff <= (r2_ext <= s_full);
         zero_ff <= (r2_ff == '0);
      end
      if (cmd.iter_en) begin
         if (take) begin
            a_ff <= trial;
            bs_ff <= (bs_ff >> 1) + rs_ff;
         end else begin
            bs_ff <= bs_ff >> 1;
         end
         rs_ff <= rs_ff >> 2;
         p_ff <= {p_ff[QW-2:0], take};
      end
      if (cmd.fin_en) begin
         if (cmd.pass) begin
            y_hold_ff <= tip;
         end else begin
            x_hold_ff <= tip;
         end
      end
      if (cmd.load_out) begin
         rsp_x_tip_ff <= zero_ff ? '0 : x_hold_ff;
         rsp_y_tip_ff <= zero_ff ? '0 : y_hold_ff;
         rsp_frame_count_ff <= cnt_ff;
         rsp_zero_radius_ff <= zero_ff;
      end
   end

   assign rsp_x_tip = rsp_x_tip_ff;
   assign rsp_y_tip = rsp_y_tip_ff;
   assign rsp_frame_count = rsp_frame_count_ff;
   assign rsp_zero_radius = rsp_zero_radius_ff;

endmodule

`default_nettype wire

FILE: sv/coordinate_frame_parser_tip_offset.sv
// Coordinate frame parser with radial tool-tip offset.
//
// Request channel (req_valid/req_ready/req_rx_byte) takes one ASCII character
// per request and recognizes frames "[X,Y]" of 1 to MAX_DIGITS decimal digits.
// Ordinary characters are taken only while no offset computation runs. A valid closing
// bracket starts the offset computation, whose result appears on the response
// channel (rsp_valid/rsp_ready, rsp_x_tip, rsp_y_tip, rsp_frame_count,
// rsp_zero_radius). Most of the computation is the bit-serial root search,
// one result bit per cycle, run once for X and once for Y. A zero radius
// skips the search and loads a zero result.
// Malformed frames are dropped and give no response.
// The result waits in an output register: characters keep flowing while the
// receiver stalls, and only the next closing bracket is held off until the
// pending response is taken. tool_offset is written through the csr_ port.
// Reset returns the parser to idle, clears the frame counter and sets
// tool_offset to 58; no clearing pass is needed.
`default_nettype none

module coordinate_frame_parser_tip_offset import cfpt_pkg::*; #(
   parameter int MAX_DIGITS = DEF_MAX_DIGITS,
   parameter int FRAC_BITS = DEF_FRAC_BITS
) (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_valid,
   output logic                     req_ready,
   input  wire [7:0]                req_rx_byte,
   output logic                     rsp_valid,
   input  wire                      rsp_ready,
   output logic signed [TIP_W-1:0]  rsp_x_tip,
   output logic signed [TIP_W-1:0]  rsp_y_tip,
   output logic [FC_W-1:0]          rsp_frame_count,
   output logic                     rsp_zero_radius,
   input  wire                      csr_psel,
   input  wire                      csr_penable,
   input  wire                      csr_pwrite,
   input  wire [CSR_ADDR_W-1:0]     csr_paddr,
   input  wire [CSR_DATA_W-1:0]     csr_pwdata,
   output logic [CSR_DATA_W-1:0]    csr_prdata,
   output logic                     csr_pready
);

   cfpt_cmd_type        cmd;
   cfpt_stat_type       stat;
   logic [OFFSET_W-1:0] tool_offset;

   cfpt_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .tool_offset (tool_offset)
   );

   cfpt_ctrl #(
      .FRAC_BITS (FRAC_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   cfpt_dp #(
      .MAX_DIGITS (MAX_DIGITS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .tool_offset     (tool_offset),
      .req_rx_byte     (req_rx_byte),
      .rsp_x_tip       (rsp_x_tip),
      .rsp_y_tip       (rsp_y_tip),
      .rsp_frame_count (rsp_frame_count),
      .rsp_zero_radius (rsp_zero_radius)
   );

endmodule

`default_nettype wire
